// ----- sv/assert_macros.svh -----
// Assertion macros for the flow sequence stamp table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSST_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define FSST_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define FSST_ASSERT_IMP(label, clk, rst, a, c)
`define FSST_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- sv/fsst_pkg.sv -----
package fsst_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int HEADER_BYTES    = 8;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   localparam logic [1:0] ACT_PEEK       = 2'd0;
   localparam logic [1:0] ACT_COMMIT     = 2'd1;
   localparam logic [1:0] ACT_UNPARSABLE = 2'd2;
   localparam logic [1:0] ACT_RESERVED   = 2'd3;

   localparam logic [2:0] VERDICT_RAW       = 3'd0;
   localparam logic [2:0] VERDICT_DROP      = 3'd1;
   localparam logic [2:0] VERDICT_STAMP     = 3'd2;
   localparam logic [2:0] VERDICT_COMMITTED = 3'd3;
   localparam logic [2:0] VERDICT_IGNORED   = 3'd4;

   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_LIMIT  = 2'd1;
   localparam logic [1:0] REG_IDLE   = 2'd2;
   localparam logic [1:0] REG_MARKS  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
      logic [31:0] port_pair;
      logic [8:0]  family_and_protocol;
      logic        rule_eligible;
      logic [15:0] packet_length;
      logic [15:0] max_payload;
      logic [63:0] now_us;
      logic [7:0]  slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        reset_flag;
      logic [47:0] sequence_res;
      logic [7:0]  flow_slot;
   } rsp_type;

   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [31:0] ports;
      logic [8:0]  proto;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [47:0] seq;
      logic [63:0] last_active;
      logic [31:0] marks_left;
      logic        eligible;
   } entry_type;

   typedef struct packed {
      logic        reorder_enabled;
      logic [8:0]  flow_limit;
      logic [31:0] idle_timeout_sec;
      logic [31:0] reset_marks;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic decide;
      logic commit_rd;
      logic commit_wb;
      logic raw;
   } cmd_type;

   typedef struct packed {
      logic commit;
      logic raw;
   } sts_type;

endpackage

// ----- sv/fsst_ram.sv -----
module fsst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/fsst_ctrl.sv -----
module fsst_ctrl #(
   parameter int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  fsst_pkg::sts_type              sts,
   output fsst_pkg::cmd_type              cmd,
   output logic [$clog2(TABLE_DEPTH)-1:0] scan_addr
);
   import fsst_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RAW    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_CRD    = 3'd5;
   localparam logic [2:0] S_CWB    = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            cnt_in   = '0;
            if (start) begin
               if (sts.commit) state_in = S_CRD;
               else if (sts.raw) state_in = S_RAW;
               else state_in = S_SCAN;
            end
         end
         S_RAW: begin
            cmd.raw  = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == AW'(TABLE_DEPTH - 1)) state_in = S_DRAIN;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_DRAIN: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_IDLE;
         end
         S_CRD: begin
            cmd.commit_rd = 1'b1;
            state_in      = S_CWB;
         end
         S_CWB: begin
            cmd.commit_wb = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign scan_addr = cnt_ff;
endmodule

// ----- sv/fsst_dp.sv -----
module fsst_dp #(
   parameter int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fsst_pkg::cmd_type              cmd,
   input  logic [$clog2(TABLE_DEPTH)-1:0] scan_addr,
   input  fsst_pkg::req_type              req_item,
   input  fsst_pkg::cfg_type              cfg,
   output fsst_pkg::sts_type              sts,
   output logic                           rsp_valid,
   output fsst_pkg::rsp_type              rsp_item
);
   import fsst_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = (CNTW > 9) ? CNTW : 9;

   req_type          req_ff;
   logic [51:0]      idle_us_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             eval_ff;
   logic [AW-1:0]    eval_idx_ff;
   logic             found_ff, vfound_ff, free_found_ff;
   logic [AW-1:0]    fidx_ff, vidx_ff, free_idx_ff;
   entry_type        fent_ff;
   logic [63:0]      vlast_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_item_ff, rsp_next;

   entry_type        rdata, wdata;
   logic             we;
   logic [AW-1:0]    waddr, raddr, cslot;
   key_type          req_key;
   logic             v_eval, key_eq, is_idle;

   logic [CW-1:0]    limit_w;
   logic             full, dec_ok, dec_create, dec_evict, dec_elig, mtu_bad, c_ok;
   logic [AW-1:0]    dec_slot;
   logic [47:0]      dec_seq;
   logic [31:0]      dec_marks;
   entry_type        new_ent, upd_ent;

   assign sts.commit = (req_item.action == ACT_COMMIT);
   assign sts.raw    = (req_item.action != ACT_PEEK) || !cfg.reorder_enabled;

   assign req_key = '{src_hi: req_ff.src_addr_hi, src_lo: req_ff.src_addr_lo,
                      dst_hi: req_ff.dst_addr_hi, dst_lo: req_ff.dst_addr_lo,
                      ports: req_ff.port_pair, proto: req_ff.family_and_protocol};
   assign cslot   = AW'(req_ff.slot);
   assign raddr   = cmd.commit_rd ? cslot : scan_addr;

   fsst_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // per-entry compare during the scan
   assign v_eval  = valid_ff[eval_idx_ff];
   assign key_eq  = (rdata.key == req_key);
   assign is_idle = v_eval && (req_ff.now_us > rdata.last_active) &&
                    ((req_ff.now_us - rdata.last_active) > {12'b0, idle_us_ff});

   always_comb begin
      limit_w = (cfg.flow_limit == 9'd0 || CW'(cfg.flow_limit) > CW'(TABLE_DEPTH)) ?
                CW'(TABLE_DEPTH) : CW'(cfg.flow_limit);
      full       = CW'(count_ff) >= limit_w;
      dec_ok     = 1'b1;
      dec_create = 1'b0;
      dec_evict  = 1'b0;
      dec_slot   = fidx_ff;
      dec_elig   = fent_ff.eligible;
      dec_seq    = fent_ff.seq;
      dec_marks  = fent_ff.marks_left;
      priority if (found_ff) begin
         dec_ok = 1'b1;
      end else if (full && !vfound_ff) begin
         dec_ok = 1'b0;
      end else begin
         dec_create = 1'b1;
         dec_evict  = full;
         dec_slot   = (full && !(free_found_ff && free_idx_ff < vidx_ff)) ?
                      vidx_ff : free_idx_ff;
         dec_elig   = req_ff.rule_eligible;
         dec_seq    = '0;
         dec_marks  = cfg.reset_marks;
      end
      mtu_bad = (17'(req_ff.packet_length) + 17'(HEADER_BYTES)) >
                17'(req_ff.max_payload);

      new_ent = '{key: req_key, seq: 48'd0, last_active: req_ff.now_us,
                  marks_left: cfg.reset_marks, eligible: req_ff.rule_eligible};
      upd_ent = rdata;
      upd_ent.seq = rdata.seq + 48'd1;
      upd_ent.marks_left = (rdata.marks_left != 32'd0) ? rdata.marks_left - 32'd1 : 32'd0;
      upd_ent.last_active = req_ff.now_us;
      c_ok = (32'(req_ff.slot) < 32'(TABLE_DEPTH)) && valid_ff[cslot] && rdata.eligible;

      we       = 1'b0;
      waddr    = dec_slot;
      wdata    = new_ent;
      valid_in = valid_ff;
      count_in = count_ff;
      rsp_next = '0;
      if (cmd.decide) begin
         we = dec_create;
         if (dec_evict) valid_in[vidx_ff] = 1'b0;
         if (dec_create) begin
            valid_in[dec_slot] = 1'b1;
            if (!dec_evict) count_in = count_ff + 1'b1;
         end
         priority if (!dec_ok || !dec_elig) begin
            rsp_next.verdict = VERDICT_RAW;
         end else if (mtu_bad) begin
            rsp_next.verdict   = VERDICT_DROP;
            rsp_next.flow_slot = 8'(dec_slot);
         end else begin
            rsp_next.verdict      = VERDICT_STAMP;
            rsp_next.reset_flag   = (dec_marks != 32'd0);
            rsp_next.sequence_res = dec_seq;
            rsp_next.flow_slot    = 8'(dec_slot);
         end
      end else if (cmd.commit_wb) begin
         we    = c_ok;
         waddr = cslot;
         wdata = upd_ent;
         rsp_next.verdict   = c_ok ? VERDICT_COMMITTED : VERDICT_IGNORED;
         rsp_next.flow_slot = req_ff.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         eval_ff      <= cmd.scan_rd;
         rsp_valid_ff <= cmd.raw || cmd.decide || cmd.commit_wb;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= scan_addr;
      if (cmd.raw || cmd.decide || cmd.commit_wb) rsp_item_ff <= rsp_next;
      if (cmd.load) begin
         req_ff        <= req_item;
         idle_us_ff    <= 52'(cfg.idle_timeout_sec) * 52'(USEC_PER_SEC);
         found_ff      <= 1'b0;
         vfound_ff     <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (eval_ff) begin
         if (v_eval && key_eq && !found_ff) begin
            found_ff <= 1'b1;
            fidx_ff  <= eval_idx_ff;
            fent_ff  <= rdata;
         end
         if (is_idle && (!vfound_ff || rdata.last_active < vlast_ff)) begin
            vfound_ff <= 1'b1;
            vidx_ff   <= eval_idx_ff;
            vlast_ff  <= rdata.last_active;
         end
         if (!v_eval && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule

// ----- sv/flow_sequence_stamp_table_core.sv -----
// Peek: one walk over the table memory, one entry read per cycle, then a drain
// step and a decide step before the result strobe. Commit: read, then write back.
// Unparsable, reserved or gated items take the raw path. One item at a time; busy holds off start.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset clears the state and config registers, valid bits and flow count; no clearing pass.
`include "assert_macros.svh"
module flow_sequence_stamp_table_core #(
   parameter int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fsst_pkg::req_type req_item,
   output logic              rsp_valid,
   output fsst_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import fsst_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic [$clog2(TABLE_DEPTH)-1:0] scan_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_ENABLE: cfg_ff.reorder_enabled  <= pwdata[0];
            REG_LIMIT:  cfg_ff.flow_limit       <= pwdata[8:0];
            REG_IDLE:   cfg_ff.idle_timeout_sec <= pwdata;
            REG_MARKS:  cfg_ff.reset_marks      <= pwdata;
            default:    cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ENABLE: prdata = {31'd0, cfg_ff.reorder_enabled};
         REG_LIMIT:  prdata = {23'd0, cfg_ff.flow_limit};
         REG_IDLE:   prdata = cfg_ff.idle_timeout_sec;
         REG_MARKS:  prdata = cfg_ff.reset_marks;
         default:    prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   fsst_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   fsst_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `FSST_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `FSST_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FSST_ASSERT_IMP(a_verdict_code, clock, reset, rsp_valid, rsp_item.verdict <= VERDICT_IGNORED)
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import fsst_pkg::*;

   localparam int DEPTH = 256;
   localparam int N_ITEMS = 500;
   localparam int N_PHASES = 5;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      rsp_type      want;
      logic [1:0]   reg_idx;
      logic [31:0]  reg_val;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   flow_sequence_stamp_table_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // shadow of the flow table
   cfg_type     shadow_cfg;
   logic        tab_valid [DEPTH];
   key_type     tab_key [DEPTH];
   logic [47:0] tab_seq [DEPTH];
   logic [63:0] tab_last [DEPTH];
   logic [31:0] tab_marks [DEPTH];
   logic        tab_elig [DEPTH];
   int          tab_count;

   rsp_type     expected_verdicts [$];
   int          stamped_slots [$];
   int          fail_count = 0;
   bit          idling_on = 1'b1;

   key_type     key_pool [8];
   logic        pool_elig [8];
   logic [63:0] now_clock = 64'd0;

   function automatic rsp_type stamp_table_predict(req_type r);
      rsp_type     o;
      key_type     k;
      int          s, lim, victim;
      logic [63:0] idle_us;
      o = '0;
      k = '{r.src_addr_hi, r.src_addr_lo, r.dst_addr_hi, r.dst_addr_lo,
            r.port_pair, r.family_and_protocol};
      if (r.action == ACT_COMMIT) begin
         o.flow_slot = r.slot;
         if (!tab_valid[r.slot] || !tab_elig[r.slot]) begin
            o.verdict = VERDICT_IGNORED;
         end else begin
            tab_seq[r.slot] = tab_seq[r.slot] + 48'd1;
            if (tab_marks[r.slot] != 0) tab_marks[r.slot] = tab_marks[r.slot] - 1;
            tab_last[r.slot] = r.now_us;
            o.verdict = VERDICT_COMMITTED;
         end
         return o;
      end
      o.verdict = VERDICT_RAW;
      if (r.action != ACT_PEEK || !shadow_cfg.reorder_enabled) return o;
      s = -1;
      for (int i = 0; i < DEPTH; i++)
         if (s < 0 && tab_valid[i] && tab_key[i] == k) s = i;
      if (s < 0) begin
         lim = shadow_cfg.flow_limit;
         if (lim == 0 || lim > DEPTH) lim = DEPTH;
         if (tab_count >= lim) begin
            idle_us = {32'd0, shadow_cfg.idle_timeout_sec} * 64'd1000000;
            victim = -1;
            for (int i = 0; i < DEPTH; i++)
               if (tab_valid[i] && r.now_us > tab_last[i] &&
                   r.now_us - tab_last[i] > idle_us)
                  if (victim < 0 || tab_last[i] < tab_last[victim]) victim = i;
            if (victim < 0) return o;
            tab_valid[victim] = 1'b0;
            if (tab_count > 0) tab_count--;
         end
         for (int i = 0; i < DEPTH; i++)
            if (s < 0 && !tab_valid[i]) s = i;
         if (s < 0) return o;
         tab_valid[s] = 1'b1;
         tab_key[s] = k;
         tab_seq[s] = '0;
         tab_marks[s] = shadow_cfg.reset_marks;
         tab_elig[s] = r.rule_eligible;
         tab_last[s] = r.now_us;
         tab_count++;
      end
      if (!tab_elig[s]) return o;
      o.flow_slot = s[7:0];
      if ({1'b0, r.packet_length} + 17'(HEADER_BYTES) > {1'b0, r.max_payload}) begin
         o.verdict = VERDICT_DROP;
      end else begin
         o.verdict = VERDICT_STAMP;
         o.reset_flag = (tab_marks[s] != 0);
         o.sequence_res = tab_seq[s];
         stamped_slots.push_back(s);
         if (stamped_slots.size() > 16) void'(stamped_slots.pop_front());
      end
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] act, key_type k, logic elig,
                                        logic [15:0] len, logic [15:0] maxp,
                                        logic [63:0] now, logic [7:0] slot);
      req_type r;
      r = '{act, k.src_hi, k.src_lo, k.dst_hi, k.dst_lo, k.ports, k.proto,
            elig, len, maxp, now, slot};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic key_type rand_key();
      key_type k;
      k = '{rand64(), rand64(), rand64(), rand64(), $urandom, 9'($urandom)};
      return k;
   endfunction

   function automatic req_type random_item();
      req_type     r;
      key_type     k;
      int          pick, roll;
      logic        elig;
      logic [15:0] len, maxp;
      pick = $urandom_range(0, 7);
      k = key_pool[pick];
      elig = pool_elig[pick];
      if ($urandom_range(0, 9) == 0) begin
         k = rand_key();
         elig = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 49) == 0) now_clock = rand64();
      else now_clock = now_clock + 64'($urandom_range(0, 3000000));
      if ($urandom_range(0, 3) == 0) begin
         len = 16'($urandom);
         maxp = 16'($urandom);
      end else begin
         len = 16'($urandom_range(0, 1500));
         maxp = 16'($urandom_range(1508, 65535));
      end
      r = make_req(ACT_PEEK, k, elig, len, maxp, now_clock, 8'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         r.action = ACT_COMMIT;
         if (stamped_slots.size() > 0 && $urandom_range(0, 4) != 0)
            r.slot = 8'(stamped_slots[$urandom_range(0, stamped_slots.size() - 1)]);
      end else if (roll < 40) begin
         r.action = ($urandom_range(0, 1) != 0) ? ACT_RESERVED : ACT_UNPARSABLE;
      end
      return r;
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {idx, 2'b00}; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ENABLE: shadow_cfg.reorder_enabled = val[0];
         REG_LIMIT:  shadow_cfg.flow_limit = val[8:0];
         REG_IDLE:   shadow_cfg.idle_timeout_sec = val;
         REG_MARKS:  shadow_cfg.reset_marks = val;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic settle();
      int guard;
      guard = 0;
      while (expected_verdicts.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DEPTH + 16) @(posedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(req_type r);
      while (idling_on && $urandom_range(0, 99) < 21) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      expected_verdicts.push_back(stamp_table_predict(r));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_checked(req_type r, rsp_type want);
      rsp_type got;
      send_item(r);
      got = expected_verdicts[$];
      if (got != want) begin
         $display("%0t predictor disagrees with table row: expected %p actual %p",
                  $time, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t unexpected item: actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            rsp_type w;
            w = expected_verdicts.pop_front();
            if (rsp_item.verdict !== w.verdict || rsp_item.reset_flag !== w.reset_flag ||
                rsp_item.sequence_res !== w.sequence_res ||
                rsp_item.flow_slot !== w.flow_slot) begin
               $display("%0t mismatch: expected %p actual %p", $time, w, rsp_item);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #50000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      row_type     rows [$];
      row_type     rw;
      key_type     ka, kb, kc, kones, kzero;
      logic [31:0] phase_cfg [N_PHASES][4];
      shadow_cfg = '0;
      tab_count = 0;
      for (int i = 0; i < DEPTH; i++) tab_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = rand_key();
         pool_elig[i] = (i != 7);
      end
      ka = rand_key(); kb = rand_key(); kc = rand_key();
      kones = '1; kzero = '0;

      rw = '{ROW_CHECKED, '0, '0, REG_ENABLE, 0};
      rw.item = make_req(ACT_PEEK, ka, 1, 0, 16'hFFFF, 64'd10, 0);
      rw.want = '{VERDICT_RAW, 0, 0, 0};
      rows.push_back(rw);
      rw.item = make_req(ACT_COMMIT, ka, 1, 0, 0, 64'd10, 8'd0);
      rw.want = '{VERDICT_IGNORED, 0, 0, 0};
      rows.push_back(rw);
      rw.item = make_req(ACT_UNPARSABLE, ka, 1, 0, 16'hFFFF, 64'd10, 0);
      rw.want = '{VERDICT_RAW, 0, 0, 0};
      rows.push_back(rw);
      rw.item = make_req(ACT_RESERVED, kones, 1, 16'hFFFF, 16'hFFFF, '1, 8'hFF);
      rows.push_back(rw);
      rw.kind = ROW_CFG;
      rw.reg_idx = REG_ENABLE; rw.reg_val = 1; rows.push_back(rw);
      rw.reg_idx = REG_LIMIT;  rw.reg_val = 2; rows.push_back(rw);
      rw.reg_idx = REG_IDLE;   rw.reg_val = 0; rows.push_back(rw);
      rw.reg_idx = REG_MARKS;  rw.reg_val = 1; rows.push_back(rw);
      rw.kind = ROW_CHECKED;
      rw.item = make_req(ACT_PEEK, ka, 1, 0, 16'hFFFF, 64'd100, 0);
      rw.want = '{VERDICT_STAMP, 1, 0, 0};
      rows.push_back(rw);
      rw.item = make_req(ACT_COMMIT, ka, 1, 0, 0, 64'd200, 8'd0);
      rw.want = '{VERDICT_COMMITTED, 0, 0, 0};
      rows.push_back(rw);
      rw.item = make_req(ACT_COMMIT, ka, 1, 0, 0, 64'd200, 8'd255);
      rw.want = '{VERDICT_IGNORED, 0, 0, 8'd255};
      rows.push_back(rw);
      rw.kind = ROW_ITEM;
      rw.item = make_req(ACT_PEEK, ka, 1, 16'd100, 16'd108, 64'd300, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, ka, 1, 16'd101, 16'd108, 64'd300, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, ka, 1, 16'hFFFF, 16'd0, 64'd300, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kb, 0, 0, 16'hFFFF, 64'd150, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_COMMIT, kb, 0, 0, 0, 64'd160, 8'd1);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kc, 1, 0, 16'hFFFF, 64'd50, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kc, 1, 0, 16'hFFFF, 64'd1000000000, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kones, 1, 0, 16'hFFFF, '1, 8'hFF);
      rows.push_back(rw);
      rw.item = make_req(ACT_COMMIT, kc, 1, 0, 0, '1, 8'd1);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kzero, 1, 0, 16'hFFFF, 64'd0, 0);
      rows.push_back(rw);
      rw.item = make_req(ACT_PEEK, kc, 1, 0, 16'hFFFF, '1, 0);
      rows.push_back(rw);

      phase_cfg[0] = '{1, 3, 1, 2};
      phase_cfg[1] = '{1, 0, 0, 32'hFFFFFFFF};
      phase_cfg[2] = '{1, 256, 32'hFFFFFFFF, 0};
      phase_cfg[3] = '{0, 1, 0, 5};
      phase_cfg[4] = '{1, 511, 2, 1};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_CFG: begin
               settle();
               csr_write(rows[i].reg_idx, rows[i].reg_val);
            end
            ROW_CHECKED: send_checked(rows[i].item, rows[i].want);
            default: send_item(rows[i].item);
         endcase
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         for (int j = 0; j < 4; j++) csr_write(2'(j), phase_cfg[p][j]);
         for (int n = 0; n < N_ITEMS / N_PHASES; n++) begin
            idling_on = !(p == 1 && n >= 20 && n < 80);
            send_item(random_item());
         end
      end

      settle();
      if (fail_count == 0 && expected_verdicts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
